@@ src/ntoe_pkg.sv @@
// Package: shared types for the heard-node table and its cell chain.
`default_nettype none

package ntoe_pkg;

    localparam int KEY_W  = 64;   // widest node key carried on the chain
    localparam int IDX_W  = 8;    // slot index on the chain, covers up to 256 cells
    localparam int TIME_W = 32;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FREE  = 2'd1,
        OUT_EVICT = 2'd2,
        OUT_READ  = 2'd3
    } outcome_t;

    // contents of one table slot, key kept apart
    typedef struct packed {
        logic                used;
        logic [3:0]          kind;
        logic                located;
        logic signed [27:0]  lat;
        logic signed [28:0]  lon;
        logic signed [10:0]  rssi;
        logic signed [7:0]   snr;
        logic [TIME_W-1:0]   seen;
    } entry_t;

    // search wavefront handed from cell to cell
    typedef struct packed {
        logic              cap;       // key hit, or read slot reached
        logic [IDX_W-1:0]  cap_idx;
        entry_t            cap_ent;
        logic [KEY_W-1:0]  cap_key;
        logic              free;      // lowest unused slot seen so far
        logic [IDX_W-1:0]  free_idx;
        logic [TIME_W-1:0] old_time;  // oldest last-seen so far
        logic [IDX_W-1:0]  old_idx;
    } scan_bus_t;

    typedef struct packed {
        logic       is_read;
        logic [3:0] read_slot;
    } scan_cmd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           ent;
        logic [KEY_W-1:0] key;
    } wr_req_t;

endpackage

`default_nettype wire

@@ src/ntoe_cell.sv @@
// One table slot: holds an entry and updates the search wavefront passing through.
`default_nettype none

module ntoe_cell
    import ntoe_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int KEY_BITS = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                tok_in,
    input  wire scan_bus_t           bus_in,
    input  wire scan_cmd_t           cmd,
    input  wire logic [KEY_BITS-1:0] key,
    input  wire wr_req_t             wr,
    output logic                     tok_out,
    output scan_bus_t                bus_out
);

    logic [KEY_BITS-1:0] key_reg;
    entry_t              ent_reg;
    logic                tok_reg;
    scan_bus_t           bus_reg;
    scan_bus_t           bus_next;
    logic                hit_here;
    logic                rd_here;
    logic                wr_here;

    always_comb begin
        bus_next = bus_in;
        hit_here = !cmd.is_read && ent_reg.used && (key_reg == key);
        rd_here  = cmd.is_read && (IDX_W'(cmd.read_slot) == IDX_W'(IDX));
        if (!bus_in.cap && (hit_here || rd_here)) begin
            bus_next.cap     = 1'b1;
            bus_next.cap_idx = IDX_W'(IDX);
            bus_next.cap_ent = ent_reg;
            bus_next.cap_key = KEY_W'(key_reg);
        end
        if (!bus_in.free && !ent_reg.used) begin
            bus_next.free     = 1'b1;
            bus_next.free_idx = IDX_W'(IDX);
        end
        // strict compare keeps the lowest index on equal times
        if ((IDX == 0) || (ent_reg.seen < bus_in.old_time)) begin
            bus_next.old_time = ent_reg.seen;
            bus_next.old_idx  = IDX_W'(IDX);
        end
    end

    assign wr_here = wr.en && (wr.idx == IDX_W'(IDX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
            key_reg <= '0;
            ent_reg <= '0;
        end else begin
            tok_reg <= tok_in;
            if (wr_here) begin
                key_reg <= wr.key[KEY_BITS-1:0];
                ent_reg <= wr.ent;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_in) begin
            bus_reg <= bus_next;
        end
    end

    assign tok_out = tok_reg;
    assign bus_out = bus_reg;

endmodule

`default_nettype wire

@@ src/node_table_oldest_eviction.sv @@
// Top level: heard-node table with key lookup, free-slot fill and oldest eviction.
//
//  channel  | dir | tdata fields (low bit up)                          | tuser
//  ---------+-----+----------------------------------------------------+--------
//  s_ input | in  | node_key, node_type, location_present, latitude_e6,| func
//           |     | longitude_e6, rssi_q, snr_q, now_ms, read_slot     |
//  m_ result| out | slot, node_count, entry_used, entry_key, entry_type,| outcome
//           |     | entry_has_location, entry_latitude, entry_longitude,|
//           |     | entry_rssi, entry_snr, entry_last_seen             |
//
// Flow: one beat in gives one beat out; the wavefront crosses the cell chain one
//   cell per cycle, and the next input beat is taken only after the result has
//   been loaded into the output register.
// s_tready is high only while no item is in the chain; a held result in the
//   output register does not block acceptance, only the final write-back step.
// A stalled m_ side holds the item in its finish step; the table is not touched
//   until the result can be loaded.
// Reset clears every slot, the node count and all handshake state.
`default_nettype none

module node_table_oldest_eviction
    import ntoe_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // node_key[63:0] node_type[67:64] location_present[68] latitude_e6[96:69]
    // longitude_e6[125:97] rssi_q[136:126] snr_q[144:137] now_ms[176:145]
    // read_slot[180:177], zero above
    input  wire logic [183:0] s_tdata,
    input  wire logic         s_tuser,   // func: 0 advert, 1 read
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // slot[3:0] node_count[8:4] entry_used[9] entry_key[73:10] entry_type[77:74]
    // entry_has_location[78] entry_latitude[106:79] entry_longitude[135:107]
    // entry_rssi[146:136] entry_snr[154:147] entry_last_seen[186:155], zero above
    output logic [191:0]      m_tdata,
    output logic [1:0]        m_tuser    // outcome
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // packed from the top down, so node_key sits in the lowest bits like s_tdata
    typedef struct packed {
        logic               func;
        logic [3:0]         read_slot;
        logic [31:0]        now;
        logic signed [7:0]  snr;
        logic signed [10:0] rssi;
        logic signed [28:0] lon;
        logic signed [27:0] lat;
        logic               loc;
        logic [3:0]         node_type;
        logic [63:0]        node_key;
    } item_t;

    state_t          state_reg;
    item_t           item_reg;
    logic            launch_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic            m_tvalid_reg;
    logic [191:0]    m_tdata_reg;
    logic [1:0]      m_tuser_reg;

    logic            s_accept;
    logic            out_free;
    logic            finish;

    // wavefront chain
    logic [ENTRIES:0] tok;
    scan_bus_t        bus [ENTRIES+1];
    scan_cmd_t        cmd;
    wr_req_t          wr;

    // finish decision
    logic [IDX_W-1:0] fin_idx;
    outcome_t         fin_outcome;
    entry_t           fin_ent;
    logic [KEY_W-1:0] fin_key;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_FINISH) && out_free;

    assign cmd.is_read   = item_reg.func;
    assign cmd.read_slot = item_reg.read_slot;

    assign tok[0] = launch_reg;
    assign bus[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ntoe_cell #(
            .IDX      (g),
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[g]),
            .bus_in  (bus[g]),
            .cmd     (cmd),
            .key     (item_reg.node_key[KEY_BITS-1:0]),
            .wr      (wr),
            .tok_out (tok[g+1]),
            .bus_out (bus[g+1])
        );
    end

    // Chain end holds its last wavefront, so the decision is stable while stalled.
    always_comb begin
        fin_idx     = bus[ENTRIES].old_idx;
        fin_outcome = OUT_EVICT;
        fin_ent     = '0;
        fin_key     = KEY_W'(item_reg.node_key[KEY_BITS-1:0]);
        cnt_next    = cnt_reg;
        if (item_reg.func) begin
            fin_idx     = IDX_W'(item_reg.read_slot);
            fin_outcome = OUT_READ;
            // slot beyond the table reads as all zero
            fin_ent     = bus[ENTRIES].cap ? bus[ENTRIES].cap_ent : '0;
            fin_key     = bus[ENTRIES].cap ? bus[ENTRIES].cap_key : '0;
        end else begin
            if (bus[ENTRIES].cap) begin
                fin_idx     = bus[ENTRIES].cap_idx;
                fin_outcome = OUT_HIT;
                // hit without location keeps the old coordinates
                fin_ent.lat = bus[ENTRIES].cap_ent.lat;
                fin_ent.lon = bus[ENTRIES].cap_ent.lon;
            end else if (bus[ENTRIES].free) begin
                fin_idx     = bus[ENTRIES].free_idx;
                fin_outcome = OUT_FREE;
                if (cnt_reg < CNT_W'(ENTRIES)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            // free and evicted slots start from zero coordinates
            fin_ent.used = 1'b1;
            fin_ent.kind = item_reg.node_type;
            fin_ent.located = item_reg.loc;
            if (item_reg.loc) begin
                fin_ent.lat = item_reg.lat;
                fin_ent.lon = item_reg.lon;
            end
            fin_ent.rssi = item_reg.rssi;
            fin_ent.snr  = item_reg.snr;
            fin_ent.seen = item_reg.now;
        end
    end

    assign wr.en  = finish && !item_reg.func;
    assign wr.idx = fin_idx;
    assign wr.ent = fin_ent;
    assign wr.key = fin_key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launch_reg   <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            launch_reg <= s_accept;
            if (m_tvalid_reg && m_tready && !finish) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        item_reg  <= {s_tuser, s_tdata[180:0]};
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (tok[ENTRIES]) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= fin_outcome;
                        m_tdata_reg  <= {5'd0, fin_ent.seen, fin_ent.snr, fin_ent.rssi,
                                         fin_ent.lon, fin_ent.lat, fin_ent.located,
                                         fin_ent.kind, fin_key, fin_ent.used,
                                         5'(cnt_next), 4'(fin_idx)};
                        cnt_reg      <= cnt_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // at most one wavefront in the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok))
        else $error("more than one wavefront in cell chain");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("node count above table size");

    a_tok_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[ENTRIES] |-> (state_reg == ST_SCAN))
        else $error("wavefront left chain outside scan");

    a_rose_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside finish step");

endmodule

`default_nettype wire
